### hw/rtl/ghan_pkg.sv
package ghan_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_SUM_BITS    = 32;

  // Field widths
  localparam int OP_W     = 2;
  localparam int COORD_W  = 6;
  localparam int WEIGHT_W = 16;
  localparam int DIM_W    = 7;
  localparam int OUT_W    = 32;

  // Q1.16 quotient
  localparam int Q_BITS = 17;
  localparam logic [Q_BITS-1:0] Q_ONE = Q_BITS'(65536);

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_ACC   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_OUTSIDE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

endpackage

### hw/rtl/grid_heatmap_accumulate_normalize.sv
// Grid heat map: cell sums in a RAM, running peak, Q1.16 normalized results.
//
// Command channel: an item (in_operation, in_col_index, in_row_index,
// in_weight) is taken on a clock edge with start high and busy low.
// Each item yields one result on out_* for exactly one cycle, flagged by
// out_strobe. There is no backpressure; the result must be taken then.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
// is always high. Write it only while busy is low and no result pending.
//
// Sequence, from the accepting edge:
//   accumulate/read in grid: busy high until the strobe, which comes
//     as busy falls. A RAM read, a read-modify-write, then a 17-step
//     restoring divider producing one quotient bit per cycle.
//   out-of-grid coordinate or unused opcode: strobe on the next cycle,
//     busy never rises, so another item can follow back to back.
//   clear: one RAM write per cycle over MAX_COLUMNS*MAX_ROWS entries,
//     strobe once the sweep ends.
// Reset (rst_n low, synchronous) sets both grid dimensions to 64, zeroes
// the peak and starts the same clearing sweep over MAX_COLUMNS*MAX_ROWS
// entries, with busy high and no result. Config writes are taken anyway.
module grid_heatmap_accumulate_normalize #(
  parameter int MAX_COLUMNS = ghan_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ghan_pkg::DEF_MAX_ROWS,
  parameter int SUM_BITS    = ghan_pkg::DEF_SUM_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // command channel
  input  logic                           start,
  output logic                           busy,
  input  logic [ghan_pkg::OP_W-1:0]      in_operation,
  input  logic [ghan_pkg::COORD_W-1:0]   in_col_index,
  input  logic [ghan_pkg::COORD_W-1:0]   in_row_index,
  input  logic [ghan_pkg::WEIGHT_W-1:0]  in_weight,
  // result channel
  output logic                           out_strobe,
  output logic [ghan_pkg::OUT_W-1:0]     out_cell_sum,
  output logic [ghan_pkg::Q_BITS-1:0]    out_normalized,
  output logic [ghan_pkg::OUT_W-1:0]     out_grid_peak,
  output logic                           out_status,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ghan_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ghan_pkg::DIM_W-1:0]     cfg_data
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int EXT_W      = SUM_BITS + 1;
  localparam int QB         = ghan_pkg::Q_BITS;
  localparam int OW         = ghan_pkg::OUT_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [ADDR_W-1:0]               clr_addr_r, clr_addr_nxt;
  logic                            clr_report_r, clr_report_nxt;
  logic [ghan_pkg::DIM_W-1:0]      cols_r, rows_r;
  logic [SUM_BITS-1:0]             peak_r, peak_nxt;
  logic [SUM_BITS-1:0]             sum_r, sum_nxt;
  logic                            acc_r, acc_nxt;
  logic [ADDR_W-1:0]               addr_r, addr_nxt;
  logic [ghan_pkg::WEIGHT_W-1:0]   weight_r, weight_nxt;

  logic                            strobe_r, strobe_nxt;
  logic [OW-1:0]                   res_sum_r, res_sum_nxt;
  logic [QB-1:0]                   res_norm_r, res_norm_nxt;
  logic [OW-1:0]                   res_peak_r, res_peak_nxt;
  logic                            res_stat_r, res_stat_nxt;

  // cell memory
  logic [SUM_BITS-1:0]             mem [CELL_COUNT];
  logic [SUM_BITS-1:0]             mem_rdata_r;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_addr;
  logic [SUM_BITS-1:0]             mem_wdata;

  logic                            outside;
  logic [ADDR_W-1:0]               in_addr;
  logic [EXT_W-1:0]                add_w;
  logic [SUM_BITS-1:0]             new_sum;

  logic                            div_go;
  logic                            div_done;
  logic [QB-1:0]                   div_quot;

  ghan_div #(
    .SUM_BITS(SUM_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (sum_nxt),
    .den  (peak_nxt),
    .done (div_done),
    .quot (div_quot)
  );

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= ghan_pkg::DIM_RESET;
      rows_r <= ghan_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ghan_pkg::CFG_COLUMNS: cols_r <= cfg_data;
        ghan_pkg::CFG_ROWS:    rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid check and address of the incoming coordinate
  always_comb begin
    outside = ({1'b0, in_col_index} >= cols_r) || ({1'b0, in_row_index} >= rows_r) ||
              (32'(in_col_index) >= 32'(MAX_COLUMNS)) ||
              (32'(in_row_index) >= 32'(MAX_ROWS));
    in_addr = ADDR_W'(32'(in_row_index) * 32'(MAX_COLUMNS) + 32'(in_col_index));
  end

  // saturating add of the weight to the stored sum
  always_comb begin
    add_w   = {1'b0, mem_rdata_r} + EXT_W'(weight_r);
    new_sum = add_w[SUM_BITS] ? '1 : add_w[SUM_BITS-1:0];
  end

  // control sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_report_nxt = clr_report_r;
    peak_nxt       = peak_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    addr_nxt       = addr_r;
    weight_nxt     = weight_r;
    strobe_nxt     = 1'b0;
    res_sum_nxt    = res_sum_r;
    res_norm_nxt   = res_norm_r;
    res_peak_nxt   = res_peak_r;
    res_stat_nxt   = res_stat_r;
    mem_we         = 1'b0;
    mem_addr       = addr_r;
    mem_wdata      = new_sum;
    div_go         = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(CELL_COUNT - 1)) begin
          state_nxt      = S_IDLE;
          clr_addr_nxt   = '0;
          clr_report_nxt = 1'b0;
          if (clr_report_r) begin
            strobe_nxt   = 1'b1;
            res_sum_nxt  = '0;
            res_norm_nxt = '0;
            res_peak_nxt = '0;
            res_stat_nxt = ghan_pkg::ST_OK;
          end
        end
      end
      S_IDLE: begin
        mem_addr = in_addr;
        if (start) begin
          priority if (in_operation == ghan_pkg::OP_CLEAR) begin
            state_nxt      = S_CLEAR;
            clr_addr_nxt   = '0;
            clr_report_nxt = 1'b1;
            peak_nxt       = '0;
          end else if ((in_operation == ghan_pkg::OP_ACC ||
                        in_operation == ghan_pkg::OP_READ) && !outside) begin
            state_nxt  = S_LOOK;
            acc_nxt    = (in_operation == ghan_pkg::OP_ACC);
            addr_nxt   = in_addr;
            weight_nxt = in_weight;
          end else begin
            // outside the grid, or unused opcode: answer at once
            strobe_nxt   = 1'b1;
            res_sum_nxt  = '0;
            res_norm_nxt = '0;
            res_peak_nxt = OW'(peak_r);
            res_stat_nxt = (in_operation == ghan_pkg::OP_ACC ||
                            in_operation == ghan_pkg::OP_READ) ?
                           ghan_pkg::ST_OUTSIDE : ghan_pkg::ST_OK;
          end
        end
      end
      S_LOOK: begin
        // read data is here: on accumulate modify, write back, raise the peak
        if (acc_r) begin
          mem_we  = 1'b1;
          sum_nxt = new_sum;
          if (new_sum > peak_r) begin
            peak_nxt = new_sum;
          end
        end else begin
          sum_nxt = mem_rdata_r;
        end
        div_go    = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt    = S_IDLE;
          strobe_nxt   = 1'b1;
          res_sum_nxt  = OW'(sum_r);
          res_norm_nxt = div_quot;
          res_peak_nxt = OW'(peak_r);
          res_stat_nxt = ghan_pkg::ST_OK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
      peak_r       <= '0;
      strobe_r     <= 1'b0;
      acc_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
      peak_r       <= peak_nxt;
      strobe_r     <= strobe_nxt;
      acc_r        <= acc_nxt;
    end
    sum_r      <= sum_nxt;
    addr_r     <= addr_nxt;
    weight_r   <= weight_nxt;
    res_sum_r  <= res_sum_nxt;
    res_norm_r <= res_norm_nxt;
    res_peak_r <= res_peak_nxt;
    res_stat_r <= res_stat_nxt;
  end

  // single-port cell RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_addr];
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = strobe_r;
  assign out_cell_sum   = res_sum_r;
  assign out_normalized = res_norm_r;
  assign out_grid_peak  = res_peak_r;
  assign out_status     = res_stat_r;

endmodule

### hw/rtl/ghan_div.sv
module ghan_div #(
  parameter int SUM_BITS = ghan_pkg::DEF_SUM_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [SUM_BITS-1:0]         num,
  input  logic [SUM_BITS-1:0]         den,
  output logic                        done,
  output logic [ghan_pkg::Q_BITS-1:0] quot
);

  localparam int QB    = ghan_pkg::Q_BITS;
  localparam int CNT_W = $clog2(QB);

  // Restoring division of (num << 16) by den, one quotient bit a cycle.
  // Caller guarantees num <= den, so the quotient fits in QB bits and the
  // partial remainder starts as num >> 1.
  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_BITS-1:0] rem_r, rem_nxt;
  logic [SUM_BITS-1:0] den_r, den_nxt;
  logic                lsb_r, lsb_nxt;
  logic [QB-1:0]       q_r, q_nxt;

  logic [SUM_BITS:0]   trial;
  logic [SUM_BITS:0]   diff;
  logic                fits;

  always_comb begin
    trial = {rem_r, (cnt_r == '0) ? lsb_r : 1'b0};
    diff  = trial - {1'b0, den_r};
    fits  = (trial >= {1'b0, den_r});
  end

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lsb_nxt  = lsb_r;
    q_nxt    = q_r;
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = num >> 1;
      lsb_nxt = num[0];
      den_nxt = den;
      q_nxt   = '0;
    end else if (run_r) begin
      rem_nxt = fits ? diff[SUM_BITS-1:0] : trial[SUM_BITS-1:0];
      q_nxt   = {q_r[QB-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QB - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lsb_r <= lsb_nxt;
    q_r   <= q_nxt;
  end

  // zero divisor gives zero; quotient never exceeds one
  assign done = done_r;
  assign quot = (den_r == '0) ? '0 : ((q_r > ghan_pkg::Q_ONE) ? ghan_pkg::Q_ONE : q_r);

endmodule

### verif/tb_grid_heatmap_accumulate_normalize.sv
`timescale 1ns / 100ps

module tb_grid_heatmap_accumulate_normalize;
  import ghan_pkg::*;

  // Block built with its default sizes
  localparam int TB_SUM_BITS = DEF_SUM_BITS;
  localparam int TB_COLS     = DEF_MAX_COLUMNS;
  localparam int TB_ROWS     = DEF_MAX_ROWS;
  localparam int CELL_TOTAL  = TB_COLS * TB_ROWS;
  localparam logic [63:0] SUM_TOP = (64'd1 << TB_SUM_BITS) - 64'd1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // idle cycles after the last result before touching the config port
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_ITEMS   = 200;

  typedef struct packed {
    logic [OUT_W-1:0]  cell_sum;
    logic [Q_BITS-1:0] normalized;
    logic [OUT_W-1:0]  grid_peak;
    logic              status;
  } heat_res_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     cfg_val;
    logic [OP_W-1:0]      op;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [WEIGHT_W-1:0]  weight;
    bit                   has_want;
    heat_res_t            want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] in_operation = '0;
  logic [COORD_W-1:0] in_col_index = '0;
  logic [COORD_W-1:0] in_row_index = '0;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic out_strobe;
  logic [OUT_W-1:0] out_cell_sum;
  logic [Q_BITS-1:0] out_normalized;
  logic [OUT_W-1:0] out_grid_peak;
  logic out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  // typed expectation that travels with the current directed item
  bit        item_has_want = 1'b0;
  heat_res_t item_want = '0;

  // predictor state
  logic [63:0] heat_cells [CELL_TOTAL];
  logic [63:0] heat_peak = '0;
  logic [DIM_W-1:0] grid_cols = DIM_RESET;
  logic [DIM_W-1:0] grid_rows = DIM_RESET;

  heat_res_t heat_expq[$];
  int err_count = 0;
  int report_count = 0;

  grid_heatmap_accumulate_normalize #(
    .MAX_COLUMNS(TB_COLS),
    .MAX_ROWS(TB_ROWS),
    .SUM_BITS(TB_SUM_BITS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_col_index(in_col_index),
    .in_row_index(in_row_index),
    .in_weight(in_weight),
    .out_strobe(out_strobe),
    .out_cell_sum(out_cell_sum),
    .out_normalized(out_normalized),
    .out_grid_peak(out_grid_peak),
    .out_status(out_status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #300_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Heat map step: updates the grid copy and returns the expected result
  function automatic heat_res_t heat_step(input logic [OP_W-1:0] op,
                                          input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          input logic [WEIGHT_W-1:0] w);
    heat_res_t r;
    int unsigned cols_eff;
    int unsigned rows_eff;
    int unsigned idx;
    logic [63:0] acc;
    logic [63:0] q;
    r = '0;
    r.status = ST_OK;
    cols_eff = (grid_cols > TB_COLS) ? TB_COLS : grid_cols;
    rows_eff = (grid_rows > TB_ROWS) ? TB_ROWS : grid_rows;
    case (op)
      OP_CLEAR: begin
        foreach (heat_cells[i]) heat_cells[i] = '0;
        heat_peak = '0;
      end
      OP_ACC, OP_READ: begin
        if (col >= cols_eff || row >= rows_eff) begin
          r.status = ST_OUTSIDE;
        end else begin
          idx = row * TB_COLS + col;
          acc = heat_cells[idx];
          if (op == OP_ACC) begin
            acc = (64'(w) > SUM_TOP - acc) ? SUM_TOP : acc + 64'(w);
            heat_cells[idx] = acc;
            if (acc > heat_peak) heat_peak = acc;
          end
          r.cell_sum = acc[OUT_W-1:0];
          // Q1.16 ratio to the peak, zero on an empty grid
          if (heat_peak == 0) begin
            q = '0;
          end else begin
            q = (acc << 16) / heat_peak;
            if (q > 64'(Q_ONE)) q = 64'(Q_ONE);
          end
          r.normalized = q[Q_BITS-1:0];
        end
      end
      default: ;
    endcase
    r.grid_peak = heat_peak[OUT_W-1:0];
    return r;
  endfunction

  // Result checker, transaction tracking and config tracking
  always @(posedge clk) begin
    heat_res_t got;
    heat_res_t want;
    heat_res_t pred;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_COLUMNS) grid_cols = cfg_data;
        else grid_rows = cfg_data;
      end
      if (out_strobe) begin
        got = '{out_cell_sum, out_normalized, out_grid_peak, out_status};
        if (heat_expq.size() == 0) begin
          err_count++;
          report_count++;
          if (report_count <= 10)
            $display("%0t: result with nothing pending: %s",
                     $time,
                     $sformatf("sum=%0d norm=%0d peak=%0d st=%0b",
                               got.cell_sum, got.normalized, got.grid_peak,
                               got.status));
        end else begin
          want = heat_expq.pop_front();
          if (got !== want) begin
            err_count++;
            report_count++;
            if (report_count <= 10)
              $display("%0t: mismatch exp %s | got %s",
                       $time,
                       $sformatf("sum=%0d norm=%0d peak=%0d st=%0b",
                                 want.cell_sum, want.normalized, want.grid_peak,
                                 want.status),
                       $sformatf("sum=%0d norm=%0d peak=%0d st=%0b",
                                 got.cell_sum, got.normalized, got.grid_peak,
                                 got.status));
          end
        end
      end
      if (start && !busy) begin
        pred = heat_step(in_operation, in_col_index, in_row_index, in_weight);
        heat_expq.push_back(item_has_want ? item_want : pred);
      end
    end
  end

  function automatic dir_row_t item_row(input logic [OP_W-1:0] op,
                                        input int unsigned col, input int unsigned row,
                                        input int unsigned w, input bit has_want,
                                        input heat_res_t want);
    dir_row_t d;
    d.is_cfg   = 1'b0;
    d.cfg_idx  = '0;
    d.cfg_val  = '0;
    d.op       = op;
    d.col      = COORD_W'(col);
    d.row      = COORD_W'(row);
    d.weight   = WEIGHT_W'(w);
    d.has_want = has_want;
    d.want     = want;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input int unsigned val);
    dir_row_t d;
    d = item_row(OP_UNUSED, 0, 0, 0, 1'b0, '0);
    d.is_cfg  = 1'b1;
    d.cfg_idx = idx;
    d.cfg_val = DIM_W'(val);
    return d;
  endfunction

  // Grid dimension for a random phase, extremes and out-of-range included
  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return 7'd1;
    if (r < 27) return 7'd64;
    if (r < 31) return 7'd0;
    if (r < 37) return DIM_W'($urandom_range(65, 127));
    return DIM_W'($urandom_range(1, 64));
  endfunction

  // Mostly a few hot cells so sums build up, plus the grid edge and noise
  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (dim == 0 || r >= 80) return COORD_W'($urandom_range(0, 63));
    if (r < 60) return COORD_W'($urandom_range(0, ((dim < 4) ? dim : 4) - 1));
    if (r < 70) return COORD_W'(dim - 1);
    if (dim < 64) return COORD_W'(dim);
    return COORD_W'($urandom_range(0, 63));
  endfunction

  // Present one command and hold it until taken; ends on a falling edge
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] col,
                           input logic [COORD_W-1:0] row, input logic [WEIGHT_W-1:0] w,
                           input bit has_want, input heat_res_t want);
    start         = 1'b1;
    in_operation  = op;
    in_col_index  = col;
    in_row_index  = row;
    in_weight     = w;
    item_has_want = has_want;
    item_want     = want;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(input bit quiet);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 15);
    else n = $urandom_range(20, 80);
    if (n != 0) begin
      start = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stop sending until every pending result is back and the block is idle
  task automatic drain();
    start = 1'b0;
    while (heat_expq.size() != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    dir_row_t dir_rows[$];
    dir_row_t d;
    bit quiet;
    int unsigned r;
    int unsigned cols_eff;
    int unsigned rows_eff;
    logic [OP_W-1:0] op;
    logic [WEIGHT_W-1:0] w;

    foreach (heat_cells[i]) heat_cells[i] = '0;

    // after reset, extremes, unused op, clear
    dir_rows.push_back(item_row(OP_READ, 0, 0, 0, 1'b1, heat_res_t'{0, 0, 0, ST_OK}));
    dir_rows.push_back(item_row(OP_ACC, 0, 0, 16'hFFFF, 1'b1,
                                heat_res_t'{65535, Q_ONE, 65535, ST_OK}));
    dir_rows.push_back(item_row(OP_ACC, 0, 0, 1, 1'b1,
                                heat_res_t'{65536, Q_ONE, 65536, ST_OK}));
    dir_rows.push_back(item_row(OP_ACC, 63, 63, 0, 1'b1, heat_res_t'{0, 0, 65536, ST_OK}));
    dir_rows.push_back(item_row(OP_ACC, 63, 0, 16'h8000, 1'b0, '0));
    dir_rows.push_back(item_row(OP_READ, 63, 0, 16'hFFFF, 1'b0, '0));
    dir_rows.push_back(item_row(OP_READ, 0, 63, 0, 1'b1, heat_res_t'{0, 0, 65536, ST_OK}));
    dir_rows.push_back(item_row(OP_UNUSED, 63, 63, 16'hFFFF, 1'b1,
                                heat_res_t'{0, 0, 65536, ST_OK}));
    dir_rows.push_back(item_row(OP_CLEAR, 63, 63, 16'hFFFF, 1'b1, heat_res_t'{0, 0, 0, ST_OK}));
    dir_rows.push_back(item_row(OP_READ, 0, 0, 0, 1'b1, heat_res_t'{0, 0, 0, ST_OK}));
    dir_rows.push_back(item_row(OP_ACC, 5, 7, 16'hAAAA, 1'b0, '0));
    dir_rows.push_back(item_row(OP_ACC, 3, 2, 16'h5555, 1'b0, '0));
    dir_rows.push_back(item_row(OP_READ, 3, 2, 0, 1'b0, '0));
    // one-cell grid; cells left outside still hold the peak
    dir_rows.push_back(cfg_row(CFG_COLUMNS, 1));
    dir_rows.push_back(cfg_row(CFG_ROWS, 1));
    dir_rows.push_back(item_row(OP_ACC, 0, 0, 100, 1'b0, '0));
    dir_rows.push_back(item_row(OP_ACC, 1, 0, 10, 1'b0, '0));
    dir_rows.push_back(item_row(OP_READ, 0, 1, 0, 1'b0, '0));
    dir_rows.push_back(item_row(OP_READ, 5, 7, 0, 1'b0, '0));
    // zero columns: everything is outside
    dir_rows.push_back(cfg_row(CFG_COLUMNS, 0));
    dir_rows.push_back(item_row(OP_ACC, 0, 0, 5, 1'b1,
                                heat_res_t'{0, 0, 16'hAAAA, ST_OUTSIDE}));
    // oversized registers saturate to the full grid
    dir_rows.push_back(cfg_row(CFG_COLUMNS, 127));
    dir_rows.push_back(cfg_row(CFG_ROWS, 65));
    dir_rows.push_back(item_row(OP_ACC, 63, 63, 16'h00FF, 1'b0, '0));
    dir_rows.push_back(item_row(OP_READ, 5, 7, 0, 1'b0, '0));

    // reset, then the clearing sweep runs with busy high
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part
    foreach (dir_rows[i]) begin
      d = dir_rows[i];
      if (d.is_cfg) begin
        drain();
        cfg_write(d.cfg_idx, d.cfg_val);
      end else begin
        send_item(d.op, d.col, d.row, d.weight, d.has_want, d.want);
        idle_gap(1'b0);
      end
    end

    // random phases, each with a fresh grid shape
    for (int p = 0; p < PHASE_COUNT; p++) begin
      quiet = ($urandom_range(0, 3) == 0);
      drain();
      cfg_write(CFG_COLUMNS, pick_dim());
      cfg_write(CFG_ROWS, pick_dim());
      cols_eff = (grid_cols > TB_COLS) ? TB_COLS : grid_cols;
      rows_eff = (grid_rows > TB_ROWS) ? TB_ROWS : grid_rows;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 999);
        if (r < 15) op = OP_CLEAR;
        else if (r < 40) op = OP_UNUSED;
        else if (r < 560) op = OP_ACC;
        else op = OP_READ;
        r = $urandom_range(0, 99);
        if (r < 10) w = 16'hFFFF;
        else if (r < 15) w = 16'h0000;
        else if (r < 45) w = WEIGHT_W'($urandom_range(0, 65535));
        else w = WEIGHT_W'($urandom_range(1, 255));
        send_item(op, pick_coord(cols_eff), pick_coord(rows_eff), w, 1'b0, '0);
        if ($urandom_range(0, 99) < 2) drain();
        else idle_gap(quiet);
      end
    end

    // wind down
    drain();
    if (err_count == 0 && heat_expq.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
